// ----- rtl/itda_pkg.sv -----
// ----------------------------------------------------------------------------
// itda_pkg
// shared types and constants of the integer to decimal ascii unit
// ----------------------------------------------------------------------------
`default_nettype none

package itda_pkg;

  localparam int unsigned MAG_W      = 64;           // magnitude width
  localparam int unsigned NUM_DIGITS = 20;           // digits of 2^64 - 1
  localparam int unsigned BCD_W      = 4 * NUM_DIGITS;
  localparam int unsigned CONV_CNT_W = $clog2(MAG_W);
  localparam int unsigned DIG_CNT_W  = $clog2(NUM_DIGITS);
  localparam int unsigned CHAR_W     = 7;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;  // '0'
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;  // '-'
  localparam logic [3:0]        DIGIT_FIVE = 4'd5;   // add-3 threshold
  localparam logic [3:0]        DIGIT_ADJ  = 4'd3;
  localparam logic [3:0]        DIGIT_NINE = 4'd9;

  // number format selected per word
  typedef enum logic [1:0] {
    KIND_S16 = 2'd0,
    KIND_S64 = 2'd1,
    KIND_U16 = 2'd2,
    KIND_U64 = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_DIGIT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;        // capture input word, init counters
    logic conv_step;   // one shift-add-3 iteration
    logic emit_sign;   // put '-' in output register
    logic emit_digit;  // put top digit in output register, shift bcd
    logic skip;        // drop a leading zero digit
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic conv_last;   // final conversion iteration
    logic neg;         // value is negative
    logic top_zero;    // current top digit is zero
    logic dig_last;    // current top digit is the units digit
    logic started;     // a digit has already been emitted
    logic out_free;    // output register can take a word
  } sts_t;

endpackage

`default_nettype wire

// ----- rtl/itda_dp.sv -----
// ----------------------------------------------------------------------------
// itda_dp
// datapath: sign/magnitude, shift-add-3 bcd conversion, output register
// ----------------------------------------------------------------------------
`default_nettype none

module itda_dp (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire itda_pkg::cmd_t                cmd,
  output itda_pkg::sts_t                     sts,
  input  wire logic [itda_pkg::MAG_W-1:0]    in_value,
  input  wire logic [1:0]                    in_kind,
  input  wire logic                          out_tready,
  output logic                               out_tvalid,
  output logic [itda_pkg::CHAR_W-1:0]        out_char,
  output logic                               out_last
);
  import itda_pkg::*;

  logic [MAG_W-1:0]      mag_r, mag_nxt;
  logic [BCD_W-1:0]      bcd_r, bcd_nxt, bcd_adj;
  logic [CONV_CNT_W-1:0] conv_cnt_r, conv_cnt_nxt;
  logic [DIG_CNT_W-1:0]  dig_cnt_r, dig_cnt_nxt;
  logic                  neg_r, neg_nxt;
  logic                  started_r, started_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]     out_char_r, out_char_nxt;
  logic                  out_last_r, out_last_nxt;
  logic [3:0]            top_digit;
  logic [15:0]           low16;
  logic [15:0]           low16_neg;
  logic [MAG_W-1:0]      value_neg;
  logic                  in_neg;
  logic [MAG_W-1:0]      in_mag;

  assign low16     = in_value[15:0];
  assign low16_neg = 16'd0 - low16;
  assign value_neg = {MAG_W{1'b0}} - in_value;
  assign top_digit = bcd_r[BCD_W-1 -: 4];

  // sign and magnitude per format
  always_comb begin
    unique case (kind_t'(in_kind))
      KIND_S16: begin
        in_neg = low16[15];
        in_mag = {{(MAG_W-16){1'b0}}, (low16[15] ? low16_neg : low16)};
      end
      KIND_S64: begin
        in_neg = in_value[MAG_W-1];
        in_mag = in_value[MAG_W-1] ? value_neg : in_value;
      end
      KIND_U16: begin
        in_neg = 1'b0;
        in_mag = {{(MAG_W-16){1'b0}}, low16};
      end
      default: begin
        in_neg = 1'b0;
        in_mag = in_value;
      end
    endcase
  end

  // add 3 to every digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      bcd_adj[4*i +: 4] = (bcd_r[4*i +: 4] >= DIGIT_FIVE) ?
                          bcd_r[4*i +: 4] + DIGIT_ADJ : bcd_r[4*i +: 4];
    end
  end

  always_comb begin
    mag_nxt       = mag_r;
    bcd_nxt       = bcd_r;
    conv_cnt_nxt  = conv_cnt_r;
    dig_cnt_nxt   = dig_cnt_r;
    neg_nxt       = neg_r;
    started_nxt   = started_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;

    if (cmd.load) begin
      mag_nxt      = in_mag;
      bcd_nxt      = '0;
      conv_cnt_nxt = CONV_CNT_W'(MAG_W - 1);
      dig_cnt_nxt  = DIG_CNT_W'(NUM_DIGITS - 1);
      neg_nxt      = in_neg;
      started_nxt  = 1'b0;
    end
    if (cmd.conv_step) begin
      bcd_nxt      = {bcd_adj[BCD_W-2:0], mag_r[MAG_W-1]};
      mag_nxt      = {mag_r[MAG_W-2:0], 1'b0};
      conv_cnt_nxt = conv_cnt_r - 1'b1;
    end
    if (cmd.emit_sign) begin
      out_valid_nxt = 1'b1;
      out_char_nxt  = CHAR_MINUS;
      out_last_nxt  = 1'b0;
    end
    if (cmd.emit_digit) begin
      out_valid_nxt = 1'b1;
      out_char_nxt  = CHAR_ZERO + {3'b000, top_digit};
      out_last_nxt  = sts.dig_last;
      started_nxt   = 1'b1;
    end
    if (cmd.emit_digit || cmd.skip) begin
      bcd_nxt = {bcd_r[BCD_W-5:0], 4'b0000};
      if (!sts.dig_last) begin
        dig_cnt_nxt = dig_cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      started_r   <= 1'b0;
      conv_cnt_r  <= '0;
      dig_cnt_r   <= '0;
      neg_r       <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      started_r   <= started_nxt;
      conv_cnt_r  <= conv_cnt_nxt;
      dig_cnt_r   <= dig_cnt_nxt;
      neg_r       <= neg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r      <= mag_nxt;
    bcd_r      <= bcd_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign sts.conv_last = (conv_cnt_r == '0);
  assign sts.neg       = neg_r;
  assign sts.top_zero  = (top_digit == 4'd0);
  assign sts.dig_last  = (dig_cnt_r == '0);
  assign sts.started   = started_r;
  assign sts.out_free  = ~out_valid_r | out_tready;

  assign out_tvalid = out_valid_r;
  assign out_char   = out_char_r;
  assign out_last   = out_last_r;

  // bcd digits stay decimal
  a_digit_decimal: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_digit |-> top_digit <= DIGIT_NINE)
    else $error("itda_dp: non-decimal digit emitted");

  // only leading zeros are dropped, never the units digit
  a_skip_zero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.skip |-> (top_digit == 4'd0) && (dig_cnt_r != '0) && !started_r)
    else $error("itda_dp: skipped a significant digit");

  // an emit never overwrites a word still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_digit || cmd.emit_sign) |-> (!out_valid_r || out_tready))
    else $error("itda_dp: output register overwritten");

endmodule

`default_nettype wire

// ----- rtl/itda_ctrl.sv -----
// ----------------------------------------------------------------------------
// itda_ctrl
// controller: sequences load, conversion, sign and digit output
// ----------------------------------------------------------------------------
`default_nettype none

module itda_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_tvalid,
  output logic                in_tready,
  output itda_pkg::cmd_t      cmd,
  input  wire itda_pkg::sts_t sts
);
  import itda_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd.conv_step = 1'b1;
        if (sts.conv_last) begin
          state_nxt = sts.neg ? ST_SIGN : ST_DIGIT;
        end
      end
      ST_SIGN: begin
        if (sts.out_free) begin
          cmd.emit_sign = 1'b1;
          state_nxt     = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        if (!sts.started && sts.top_zero && !sts.dig_last) begin
          cmd.skip = 1'b1;
        end else if (sts.out_free) begin
          cmd.emit_digit = 1'b1;
          if (sts.dig_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.conv_step, cmd.emit_sign, cmd.emit_digit, cmd.skip}))
    else $error("itda_ctrl: several commands at once");

  a_load_conv: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == ST_CONV)
    else $error("itda_ctrl: load not followed by conversion");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_digit && sts.dig_last) |=> state_r == ST_IDLE)
    else $error("itda_ctrl: did not return to idle after last digit");

endmodule

`default_nettype wire

// ----- rtl/integer_to_decimal_ascii_unit.sv -----
// ----------------------------------------------------------------------------
// integer_to_decimal_ascii_unit
// prints a 16- or 64-bit signed or unsigned integer as decimal ascii
// ----------------------------------------------------------------------------
// One input word carries a 64-bit pattern and a format (signed 16, signed 64,
// unsigned 16, unsigned 64; the 16-bit formats use only the low 16 bits).
// The unit answers with one output word per character: '-' first for a
// negative value, then the decimal digits most significant first, no leading
// zeros, zero printed as a single '0'; tlast marks the final character.
// Steps per word: an accept state, shift-add-3 binary to bcd conversion
// (one bit per cycle through a 20-digit bcd register), the sign when
// negative, then the 20 digit positions, in which leading zeros are
// dropped one per cycle and the rest are written to the output register
// whenever it is free. Without backpressure the conversion loop takes
// most of the time per word. A new word is taken once the final character
// sits in the output register, while it may still wait for out_tready.
`default_nettype none

module integer_to_decimal_ascii_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // [63:0] value
  input  wire logic [1:0]  in_tuser,   // [1:0] kind
  // result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // [6:0] char_code, [7] zero
  output logic             out_tlast   // is_last
);
  import itda_pkg::*;

  cmd_t              cmd;
  sts_t              sts;
  logic [CHAR_W-1:0] out_char;

  // sequencing of one word
  itda_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // magnitude, bcd conversion and output register
  itda_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_value   (in_tdata),
    .in_kind    (in_tuser),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_char   (out_char),
    .out_last   (out_tlast)
  );

  // pad the 7-bit character to a whole byte
  assign out_tdata = {1'b0, out_char};

endmodule

`default_nettype wire

// ----- sim/itda_char_checker.sv -----
// ----------------------------------------------------------------------------
// itda_char_checker
// watches both channels of the decimal ascii unit and checks every character
// ----------------------------------------------------------------------------
// Each accepted input word is expanded into the characters it should print:
// sign first for a negative value, then the digits most significant first.
// Those wait in order. Each accepted output word is compared with the oldest
// one: character code, the zero pad bit of tdata, and tlast.
// ----------------------------------------------------------------------------
`default_nettype none

module itda_char_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [63:0] in_tdata,   // [63:0] value
  input  wire logic [1:0]  in_tuser,   // [1:0] kind
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [7:0]  out_tdata,  // [6:0] char_code, [7] zero
  input  wire logic        out_tlast,  // is_last
  output int               mismatches,
  output int               chars_outstanding
);

  timeunit 1ns;
  timeprecision 1ps;

  import itda_pkg::*;

  localparam logic [63:0] DEC_BASE = 64'd10;

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
  } print_char_t;

  print_char_t chars_due[$];

  initial begin
    mismatches        = 0;
    chars_outstanding = 0;
  end

  task automatic flag_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    mismatches++;
  endtask

  // expands one number into the characters it prints
  function automatic void queue_printout(input logic [63:0] value, input kind_t kind);
    logic [63:0] mag;
    logic        neg;
    logic [3:0]  digs [NUM_DIGITS];
    int          nd;
    print_char_t c;
    neg = 1'b0;
    nd  = 0;
    case (kind)
      KIND_S16: begin
        neg = value[15];
        mag = neg ? {48'd0, 16'(~value[15:0] + 16'd1)} : {48'd0, value[15:0]};
      end
      KIND_S64: begin
        neg = value[63];
        mag = neg ? (~value + 64'd1) : value;
      end
      KIND_U16: mag = {48'd0, value[15:0]};
      default:  mag = value;
    endcase
    do begin
      digs[nd] = 4'(mag % DEC_BASE);
      mag      = mag / DEC_BASE;
      nd++;
    end while (mag != 64'd0 && nd < NUM_DIGITS);
    if (neg) begin
      c.code = CHAR_MINUS;
      c.last = 1'b0;
      chars_due.push_back(c);
    end
    for (int k = nd - 1; k >= 0; k--) begin
      c.code = CHAR_ZERO + CHAR_W'(digs[k]);
      c.last = (k == 0);
      chars_due.push_back(c);
    end
  endfunction

  always @(posedge clk) begin
    print_char_t want;
    if (rst_n) begin
      // output side first: a word leaving now can only belong to an older number
      if (out_tvalid && out_tready) begin
        if (chars_due.size() == 0) begin
          flag_mismatch($sformatf("unexpected char 0x%02h last %0b", out_tdata, out_tlast));
        end else begin
          want = chars_due.pop_front();
          if (out_tdata[6:0] !== want.code)
            flag_mismatch($sformatf("char_code 0x%02h, wanted 0x%02h",
                                    out_tdata[6:0], want.code));
          if (out_tdata[7] !== 1'b0)
            flag_mismatch("tdata pad bit not zero");
          if (out_tlast !== want.last)
            flag_mismatch($sformatf("tlast %0b, wanted %0b on char 0x%02h",
                                    out_tlast, want.last, want.code));
        end
      end
      if (in_tvalid && in_tready)
        queue_printout(in_tdata, kind_t'(in_tuser));
    end
    chars_outstanding <= chars_due.size();
  end

endmodule

`default_nettype wire

// ----- sim/tb_integer_to_decimal_ascii_unit.sv -----
// ----------------------------------------------------------------------------
// tb_integer_to_decimal_ascii_unit
// stimulus and verdict for the integer to decimal ascii unit
// ----------------------------------------------------------------------------
// A directed set of numbers hits the edges of every format: zero, the
// largest and most negative values, twenty-digit values and junk in the
// upper bits of the 16-bit formats. Random numbers of every length and
// powers of ten plus or minus one follow. Both channels idle at random;
// the checker beside the unit does all prediction and comparison.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_integer_to_decimal_ascii_unit;

  timeunit 1ns;
  timeprecision 1ps;

  import itda_pkg::*;

  localparam int RANDOM_WORDS = 200;
  localparam int TAIL_CYCLES  = 200;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;   // [63:0] value
  logic [1:0]  in_tuser;   // [1:0] kind
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;  // [6:0] char_code, [7] zero
  logic        out_tlast;  // is_last

  int mismatches;
  int chars_outstanding;

  integer_to_decimal_ascii_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  itda_char_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_tvalid         (in_tvalid),
    .in_tready         (in_tready),
    .in_tdata          (in_tdata),
    .in_tuser          (in_tuser),
    .out_tvalid        (out_tvalid),
    .out_tready        (out_tready),
    .out_tdata         (out_tdata),
    .out_tlast         (out_tlast),
    .mismatches        (mismatches),
    .chars_outstanding (chars_outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // mostly no gap, often a short one, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // offers one word after a random gap and returns once it is taken
  task automatic send_word(input logic [63:0] value, input kind_t kind);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    in_tuser  <= kind;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // receiver side: bursts of ready with random stalls, sometimes a long clean run
  initial begin
    int stall;
    out_tready <= 1'b0;
    @(posedge clk);
    forever begin
      out_tready <= 1'b1;
      if ($urandom_range(0, 19) == 0)
        repeat (300) @(posedge clk);
      else
        repeat ($urandom_range(1, 12)) @(posedge clk);
      stall = idle_len();
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  initial begin
    logic [63:0] value;
    logic [63:0] pow10;
    kind_t       kind;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= 64'd0;
    in_tuser  <= KIND_U64;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // signed 16: zero, extremes, minus one, junk above bit 15
    send_word(64'd0,                   KIND_S16);
    send_word(64'h0000_0000_0000_7FFF, KIND_S16);
    send_word(64'h0000_0000_0000_8000, KIND_S16);
    send_word(64'h0000_0000_0000_FFFF, KIND_S16);
    send_word(64'hDEAD_BEEF_0000_1234, KIND_S16);
    send_word(64'hFFFF_FFFF_FFFF_8000, KIND_S16);
    // signed 64: zero, one, extremes, minus one
    send_word(64'd0,                   KIND_S64);
    send_word(64'd1,                   KIND_S64);
    send_word(64'h7FFF_FFFF_FFFF_FFFF, KIND_S64);
    send_word(64'h8000_0000_0000_0000, KIND_S64);
    send_word(64'hFFFF_FFFF_FFFF_FFFF, KIND_S64);
    // unsigned 16: extremes, digit rollover, upper bits dropped
    send_word(64'd0,                   KIND_U16);
    send_word(64'h0000_0000_0000_FFFF, KIND_U16);
    send_word(64'hFFFF_FFFF_FFFF_0000, KIND_U16);
    send_word(64'd9,                   KIND_U16);
    send_word(64'd10,                  KIND_U16);
    // unsigned 64: zero, one, twenty-digit values
    send_word(64'd0,                   KIND_U64);
    send_word(64'd1,                   KIND_U64);
    send_word(64'hFFFF_FFFF_FFFF_FFFF, KIND_U64);
    send_word(64'h8AC7_2304_89E8_0000, KIND_U64);  // 10^19
    send_word(64'h8AC7_2304_89E7_FFFF, KIND_U64);  // 10^19 - 1

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      kind = kind_t'($urandom_range(0, 3));
      case ($urandom_range(0, 3))
        0: value = {$urandom, $urandom};
        1: begin
          // powers of ten and their neighbors, where digit counts change
          pow10 = 64'd1;
          repeat ($urandom_range(0, 19)) pow10 = pow10 * 64'd10;
          value = pow10 + 64'($urandom_range(0, 2)) - 64'd1;
        end
        default: value = {$urandom, $urandom} >> $urandom_range(0, 63);
      endcase
      send_word(value, kind);
    end
    in_tvalid <= 1'b0;

    @(posedge clk);
    while (chars_outstanding != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  // generous bound on the slowest legal run
  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

`default_nettype wire

// ----- integer_to_decimal_ascii_unit.f -----
rtl/itda_pkg.sv
rtl/itda_dp.sv
rtl/itda_ctrl.sv
rtl/integer_to_decimal_ascii_unit.sv
sim/itda_char_checker.sv
sim/tb_integer_to_decimal_ascii_unit.sv
